// ----- sv/ise_pkg.sv -----
package ise_pkg;

	localparam int TIME_WIDTH_DEF = 32;

	// shared divider: signed dividend, unsigned nonzero divisor
	localparam int DIV_NW = 32;
	localparam int DIV_DW = 16;

	// x / 1000 by reciprocal: ceil(2^34 / 1000), exact for |x| < 2^24
	localparam logic [24:0] RECIP_1000 = 25'd17179870;

	localparam logic [7:0]  RST_SCROLL_DIVISOR   = 8'd48;
	localparam logic        RST_Y_NEGATE         = 1'b0;
	localparam logic [16:0] RST_MIN_LAUNCH_SPEED = 17'd12000;
	localparam logic [16:0] RST_MAX_LAUNCH_SPEED = 17'd30000;
	localparam logic [13:0] RST_DECAY_TIME_MS    = 14'd920;
	localparam logic [16:0] RST_STOP_SPEED       = 17'd8000;
	localparam logic [9:0]  RST_PEAK_HOLD_MS     = 10'd120;
	localparam logic [9:0]  RST_LIFT_TIMEOUT_MS  = 10'd20;

	// register indexes (byte address / 4)
	localparam logic [2:0] REG_SCROLL_DIVISOR   = 3'd0;
	localparam logic [2:0] REG_Y_NEGATE         = 3'd1;
	localparam logic [2:0] REG_MIN_LAUNCH_SPEED = 3'd2;
	localparam logic [2:0] REG_MAX_LAUNCH_SPEED = 3'd3;
	localparam logic [2:0] REG_DECAY_TIME_MS    = 3'd4;
	localparam logic [2:0] REG_STOP_SPEED       = 3'd5;
	localparam logic [2:0] REG_PEAK_HOLD_MS     = 3'd6;
	localparam logic [2:0] REG_LIFT_TIMEOUT_MS  = 3'd7;

	typedef struct packed {
		logic [7:0]  scroll_divisor;
		logic        y_negate;
		logic [16:0] min_launch_speed;
		logic [16:0] max_launch_speed;
		logic [13:0] decay_time_ms;
		logic [16:0] stop_speed;
		logic [9:0]  peak_hold_ms;
		logic [9:0]  lift_timeout_ms;
	} cfg_t;

	typedef logic [3:0] dp_op_t;
	localparam dp_op_t OP_NONE    = 4'd0;
	localparam dp_op_t OP_PRE     = 4'd1;
	localparam dp_op_t OP_DRAG_A  = 4'd2;
	localparam dp_op_t OP_DRAG_B  = 4'd3;
	localparam dp_op_t OP_DRAG_C  = 4'd4;
	localparam dp_op_t OP_LAUNCH  = 4'd5;
	localparam dp_op_t OP_COAST_A = 4'd6;
	localparam dp_op_t OP_COAST_B = 4'd7;
	localparam dp_op_t OP_COAST_C = 4'd8;
	localparam dp_op_t OP_COAST_D = 4'd9;
	localparam dp_op_t OP_LOAD    = 4'd10;

	typedef struct packed {
		logic   in_take;
		dp_op_t op;
		logic   axis;
	} dp_cmd_t;

	typedef struct packed {
		logic drag;
		logic div_done;
	} dp_stat_t;

	function automatic logic signed [7:0] sat127(input logic signed [10:0] v);
		if (v > 11'sd127)
			return 8'sd127;
		else if (v < -11'sd127)
			return -8'sd127;
		else
			return v[7:0];
	endfunction

	// quotient toward zero on magnitudes, keep bits 49:34 of the product
	function automatic logic signed [24:0] quo1000(input logic signed [24:0] v);
		logic [24:0]        m;
		logic [49:0]        p;
		logic signed [24:0] q;
		m = v[24] ? 25'(-v) : 25'(v);
		p = {25'd0, m} * {25'd0, RECIP_1000};
		q = $signed({9'd0, p[49:34]});
		return v[24] ? -q : q;
	endfunction

endpackage

// ----- sv/inertial_scroll_engine.sv -----
// Inertial scroll engine. One result transaction leaves for every input transaction
// (one pointing report), in order. While fn_held is set, motion becomes wheel notches
// and each axis tracks its speed; after lift, a decaying coast keeps emitting notches.
// The single shared radix-2 divider sets the pace: a report needs two quotients per
// axis while dragging and one per axis when not, and the coast's divisions by 1000
// use a reciprocal multiply instead of the divider.
// One report is worked on at a time; the finished result sits in an output register,
// so the next report is accepted while that result still waits for out_ready.
// Registers sit on an APB-style port at byte address 4*index; pready is always high.
module inertial_scroll_engine import ise_pkg::*; #(
	parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	// report transaction
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [31:0]       time_ms,
	input  logic signed [7:0] move_x,
	input  logic signed [7:0] move_y,
	input  logic signed [7:0] wheel_h_in,
	input  logic signed [7:0] wheel_v_in,
	input  logic              buttons_active,
	input  logic              fn_held,
	input  logic              key_kill,
	// result transaction
	output logic              out_valid,
	input  logic              out_ready,
	output logic signed [7:0] move_x_out,
	output logic signed [7:0] move_y_out,
	output logic signed [7:0] wheel_h_out,
	output logic signed [7:0] wheel_v_out,
	// configuration
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [4:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	cfg_t       cfg_q;
	dp_cmd_t    cmd;
	dp_stat_t   stat;
	logic       wr;
	logic [2:0] ridx;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite;
	assign ridx   = paddr[4:2];

	// register file; writes land on the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.scroll_divisor   <= RST_SCROLL_DIVISOR;
			cfg_q.y_negate         <= RST_Y_NEGATE;
			cfg_q.min_launch_speed <= RST_MIN_LAUNCH_SPEED;
			cfg_q.max_launch_speed <= RST_MAX_LAUNCH_SPEED;
			cfg_q.decay_time_ms    <= RST_DECAY_TIME_MS;
			cfg_q.stop_speed       <= RST_STOP_SPEED;
			cfg_q.peak_hold_ms     <= RST_PEAK_HOLD_MS;
			cfg_q.lift_timeout_ms  <= RST_LIFT_TIMEOUT_MS;
		end else if (wr) begin
			unique case (ridx)
				REG_SCROLL_DIVISOR:   cfg_q.scroll_divisor   <= pwdata[7:0];
				REG_Y_NEGATE:         cfg_q.y_negate         <= pwdata[0];
				REG_MIN_LAUNCH_SPEED: cfg_q.min_launch_speed <= pwdata[16:0];
				REG_MAX_LAUNCH_SPEED: cfg_q.max_launch_speed <= pwdata[16:0];
				REG_DECAY_TIME_MS:    cfg_q.decay_time_ms    <= pwdata[13:0];
				REG_STOP_SPEED:       cfg_q.stop_speed       <= pwdata[16:0];
				REG_PEAK_HOLD_MS:     cfg_q.peak_hold_ms     <= pwdata[9:0];
				REG_LIFT_TIMEOUT_MS:  cfg_q.lift_timeout_ms  <= pwdata[9:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (ridx)
			REG_SCROLL_DIVISOR:   prdata = 32'(cfg_q.scroll_divisor);
			REG_Y_NEGATE:         prdata = 32'(cfg_q.y_negate);
			REG_MIN_LAUNCH_SPEED: prdata = 32'(cfg_q.min_launch_speed);
			REG_MAX_LAUNCH_SPEED: prdata = 32'(cfg_q.max_launch_speed);
			REG_DECAY_TIME_MS:    prdata = 32'(cfg_q.decay_time_ms);
			REG_STOP_SPEED:       prdata = 32'(cfg_q.stop_speed);
			REG_PEAK_HOLD_MS:     prdata = 32'(cfg_q.peak_hold_ms);
			REG_LIFT_TIMEOUT_MS:  prdata = 32'(cfg_q.lift_timeout_ms);
			default:              prdata = '0;
		endcase
	end

	// sequencer: steps the datapath through drag or coast for both axes
	ise_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// axis state, shared divider and output register
	ise_dp #(
		.TW (TIME_WIDTH)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.cfg            (cfg_q),
		.time_ms        (time_ms),
		.move_x         (move_x),
		.move_y         (move_y),
		.wheel_h_in     (wheel_h_in),
		.wheel_v_in     (wheel_v_in),
		.buttons_active (buttons_active),
		.fn_held        (fn_held),
		.key_kill       (key_kill),
		.move_x_out     (move_x_out),
		.move_y_out     (move_y_out),
		.wheel_h_out    (wheel_h_out),
		.wheel_v_out    (wheel_v_out)
	);

endmodule

// ----- sv/ise_div.sv -----
module ise_div import ise_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic signed [DIV_NW-1:0] dividend,
	input  logic [DIV_DW-1:0]        divisor,
	output logic                     done,
	output logic signed [DIV_NW-1:0] quot,
	output logic signed [DIV_DW:0]   rem
);

	localparam int CW = $clog2(DIV_NW);

	logic              busy_q, done_q, neg_q;
	logic [CW-1:0]     cnt_q;
	logic [DIV_DW:0]   acc_q;
	logic [DIV_NW-1:0] q_q;
	logic [DIV_DW-1:0] dvs_q;
	logic [DIV_DW:0]   trial;
	logic              fits;

	// restoring, one quotient bit per cycle on magnitudes
	assign trial = {acc_q[DIV_DW-1:0], q_q[DIV_NW-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(DIV_NW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[DIV_NW-1];
			q_q   <= dividend[DIV_NW-1] ? DIV_NW'(-dividend) : DIV_NW'(dividend);
			acc_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			acc_q <= fits ? trial - {1'b0, dvs_q} : trial;
			q_q   <= {q_q[DIV_NW-2:0], fits};
		end
	end

	assign done = done_q;
	assign quot = neg_q ? -$signed(q_q) : $signed(q_q);
	assign rem  = neg_q ? -$signed(acc_q) : $signed(acc_q);

endmodule

// ----- sv/ise_dp.sv -----
module ise_dp import ise_pkg::*; #(
	parameter int TW = TIME_WIDTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  dp_cmd_t            cmd,
	output dp_stat_t           stat,
	input  cfg_t               cfg,
	input  logic [31:0]        time_ms,
	input  logic signed [7:0]  move_x,
	input  logic signed [7:0]  move_y,
	input  logic signed [7:0]  wheel_h_in,
	input  logic signed [7:0]  wheel_v_in,
	input  logic               buttons_active,
	input  logic               fn_held,
	input  logic               key_kill,
	output logic signed [7:0]  move_x_out,
	output logic signed [7:0]  move_y_out,
	output logic signed [7:0]  wheel_h_out,
	output logic signed [7:0]  wheel_v_out
);

	localparam logic signed [29:0] NUM_SCALE = 30'sd1000000;
	localparam logic signed [23:0] INST_MAX  = 24'sd8388607;

	// report being worked on
	logic [TW-1:0]      now_q;
	logic signed [7:0]  x_q, y_q, h_q, v_q;
	logic               btn_q, fn_q, kill_q;

	// per-axis state
	logic signed [15:0] rem_q   [2];
	logic signed [23:0] avg_q   [2];
	logic signed [23:0] peak_q  [2];
	logic [TW-1:0]      ptime_q [2];
	logic signed [17:0] cspd_q  [2];
	logic signed [15:0] cfrac_q [2];
	logic [TW-1:0]      mtime_q [2];
	logic signed [9:0]  n_q     [2];

	logic [TW-1:0]      last_tick_q, last_touch_q;
	logic               pending_q;
	logic [6:0]         dt_q;
	logic signed [24:0] prod_q;
	logic signed [16:0] fsum_q;

	logic               a;
	logic [7:0]         div_eff;
	logic [13:0]        tau_eff;
	logic signed [8:0]  raw;
	logic               moved, act;
	logic [TW-1:0]      tick_diff, gap_diff, pk_diff, lift_diff;
	logic [6:0]         dt_c;
	logic               gap_big;
	logic [7:0]         gap8;
	logic signed [29:0] num;
	logic [15:0]        den;
	logic signed [24:0] prod_c;
	logic signed [16:0] rsum;

	logic                     div_start, div_done;
	logic signed [DIV_NW-1:0] div_a, dq;
	logic [DIV_DW-1:0]        div_b;
	logic signed [DIV_DW:0]   dr;

	// ema and peak
	logic signed [23:0] inst, new_avg;
	logic signed [24:0] ema_d, ema_q4;
	logic [23:0]        abs_avg, abs_peak;
	logic               peak_take;

	// decay and coast notches
	logic signed [24:0] dec, nsp, spd25, st25, cn, crem;
	logic [24:0]        abs_dec, abs_spd;
	logic               spd_on;

	// launch
	logic signed [24:0] mx25, mn25, lv [2];
	logic               lgo [2];
	logic               lift;

	assign a       = cmd.axis;
	assign div_eff = (cfg.scroll_divisor == 8'd0) ? 8'd1 : cfg.scroll_divisor;
	assign tau_eff = (cfg.decay_time_ms == 14'd0) ? 14'd1 : cfg.decay_time_ms;
	assign moved   = (x_q != 8'sd0) || (y_q != 8'sd0);
	assign act     = moved || (h_q != 8'sd0) || (v_q != 8'sd0) || btn_q || kill_q;

	always_comb begin
		if (!a)
			raw = 9'(x_q);
		else if (cfg.y_negate)
			raw = -9'(y_q);
		else
			raw = 9'(y_q);
	end

	assign tick_diff = now_q - last_tick_q;
	assign dt_c = (tick_diff == '0) ? 7'd1 :
		(tick_diff > TW'(100)) ? 7'd100 : tick_diff[6:0];

	assign gap_diff = now_q - mtime_q[a];
	assign gap_big  = gap_diff > TW'(200);
	assign gap8 = gap_big ? 8'd200 : (gap_diff == '0) ? 8'd1 : gap_diff[7:0];

	assign num    = 30'(raw) * NUM_SCALE;
	assign den    = {8'd0, div_eff} * {8'd0, gap8};
	assign prod_c = 25'(cspd_q[a]) * $signed({18'd0, dt_q});
	assign rsum   = 17'(rem_q[a]) + 17'(raw);

	always_comb begin
		div_start = 1'b0;
		div_a     = '0;
		div_b     = DIV_DW'(1000);
		unique case (cmd.op)
			OP_DRAG_A: begin
				div_start = 1'b1;
				div_a     = DIV_NW'(rsum);
				div_b     = {8'd0, div_eff};
			end
			OP_DRAG_B: begin
				div_start = 1'b1;
				div_a     = DIV_NW'(num);
				div_b     = den;
			end
			OP_COAST_C: begin
				div_start = 1'b1;
				div_a     = DIV_NW'(prod_q);
				div_b     = {2'd0, tau_eff};
			end
			default: ;
		endcase
	end

	ise_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_a),
		.divisor  (div_b),
		.done     (div_done),
		.quot     (dq),
		.rem      (dr)
	);

	// instant speed saturated, then quarter-weight EMA (trunc toward zero)
	always_comb begin
		if (dq > DIV_NW'(INST_MAX))
			inst = INST_MAX;
		else if (dq < -DIV_NW'(INST_MAX))
			inst = -INST_MAX;
		else
			inst = dq[23:0];
		ema_d     = 25'(inst) - 25'(avg_q[a]);
		ema_q4    = (ema_d + (ema_d[24] ? 25'sd3 : 25'sd0)) >>> 2;
		new_avg   = avg_q[a] + 24'(ema_q4);
		abs_avg   = new_avg[23] ? 24'(-new_avg) : 24'(new_avg);
		abs_peak  = peak_q[a][23] ? 24'(-peak_q[a]) : 24'(peak_q[a]);
		pk_diff   = now_q - ptime_q[a];
		peak_take = (abs_avg >= abs_peak) || (pk_diff > TW'(cfg.peak_hold_ms));
	end

	always_comb begin
		spd25  = 25'(cspd_q[a]);
		spd_on = cspd_q[a] != 18'sd0;
		st25   = $signed({8'd0, cfg.stop_speed});
		// whole notches out of the fraction sum, rest stays as fraction
		cn     = quo1000(25'(fsum_q));
		crem   = 25'(fsum_q) - cn * 25'sd1000;
		dec    = dq[24:0];
		if (dec == 25'sd0)
			dec = spd25[24] ? -25'sd1 : 25'sd1;
		abs_dec = dec[24] ? 25'(-dec) : 25'(dec);
		abs_spd = spd25[24] ? 25'(-spd25) : 25'(spd25);
		if (abs_dec > abs_spd)
			dec = spd25;
		nsp = spd25 - dec;
	end

	assign mx25      = $signed({8'd0, cfg.max_launch_speed});
	assign mn25      = $signed({8'd0, cfg.min_launch_speed});
	assign lift_diff = now_q - last_touch_q;
	assign lift      = pending_q && !moved && (lift_diff >= TW'(cfg.lift_timeout_ms));

	always_comb begin
		for (int i = 0; i < 2; i++) begin
			if (peak_q[i] > 24'(mx25))
				lv[i] = mx25;
			else if (25'(peak_q[i]) < -mx25)
				lv[i] = -mx25;
			else
				lv[i] = 25'(peak_q[i]);
			lgo[i] = !((lv[i] < mn25) && (lv[i] > -mn25));
		end
	end

	assign stat.drag     = fn_q && moved;
	assign stat.div_done = div_done;

	always_ff @(posedge clk) begin
		if (cmd.in_take) begin
			now_q  <= TW'(time_ms);
			x_q    <= move_x;
			y_q    <= move_y;
			h_q    <= wheel_h_in;
			v_q    <= wheel_v_in;
			btn_q  <= buttons_active;
			fn_q   <= fn_held;
			kill_q <= key_kill;
		end
		if (cmd.op == OP_PRE)
			dt_q <= dt_c;
		if (cmd.op == OP_COAST_A)
			prod_q <= prod_c;
		if (cmd.op == OP_COAST_B)
			fsum_q <= 17'(cfrac_q[a]) + 17'(quo1000(prod_q));
		if (cmd.op == OP_LOAD) begin
			move_x_out  <= fn_q ? 8'sd0 : sat127(11'(x_q));
			move_y_out  <= fn_q ? 8'sd0 : sat127(11'(y_q));
			wheel_h_out <= sat127(11'(h_q) + 11'(n_q[0]));
			wheel_v_out <= sat127(11'(v_q) + 11'(n_q[1]));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 2; i++) begin
				rem_q[i]   <= '0;
				avg_q[i]   <= '0;
				peak_q[i]  <= '0;
				ptime_q[i] <= '0;
				cspd_q[i]  <= '0;
				cfrac_q[i] <= '0;
				mtime_q[i] <= '0;
				n_q[i]     <= '0;
			end
			last_tick_q  <= '0;
			last_touch_q <= '0;
			pending_q    <= 1'b0;
		end else begin
			unique case (cmd.op)
				OP_PRE: begin
					last_tick_q <= now_q;
					n_q[0]      <= '0;
					n_q[1]      <= '0;
					if (act) begin
						cspd_q[0]  <= '0;
						cspd_q[1]  <= '0;
						cfrac_q[0] <= '0;
						cfrac_q[1] <= '0;
					end
					if (fn_q && moved) begin
						last_touch_q <= now_q;
						pending_q    <= 1'b1;
					end else if (act && (!fn_q || kill_q)) begin
						pending_q <= 1'b0;
					end
				end
				OP_DRAG_B: begin
					rem_q[a] <= dr[15:0];
					n_q[a]   <= dq[9:0];
					if (raw != 9'sd0 && gap_big) begin
						avg_q[a]  <= '0;
						peak_q[a] <= '0;
					end
				end
				OP_DRAG_C: begin
					if (raw != 9'sd0) begin
						avg_q[a]   <= new_avg;
						mtime_q[a] <= now_q;
						if (peak_take) begin
							peak_q[a]  <= new_avg;
							ptime_q[a] <= now_q;
						end
					end
				end
				OP_LAUNCH: begin
					if (lift) begin
						pending_q <= 1'b0;
						for (int i = 0; i < 2; i++) begin
							if (lgo[i]) begin
								cspd_q[i]  <= lv[i][17:0];
								cfrac_q[i] <= '0;
								rem_q[i]   <= '0;
							end
						end
					end
				end
				OP_COAST_D: begin
					if (spd_on) begin
						n_q[a] <= cn[9:0];
						if ((nsp < st25) && (nsp > -st25)) begin
							cspd_q[a]  <= '0;
							cfrac_q[a] <= '0;
						end else begin
							cspd_q[a]  <= nsp[17:0];
							cfrac_q[a] <= crem[15:0];
						end
					end
				end
				default: ;
			endcase
		end
	end

endmodule

// ----- sv/ise_ctrl.sv -----
module ise_ctrl import ise_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_PRE    = 4'd1;
	localparam logic [3:0] S_DA     = 4'd2;
	localparam logic [3:0] S_DB     = 4'd3;
	localparam logic [3:0] S_DC     = 4'd4;
	localparam logic [3:0] S_LAUNCH = 4'd5;
	localparam logic [3:0] S_CA     = 4'd6;
	localparam logic [3:0] S_CB     = 4'd7;
	localparam logic [3:0] S_CC     = 4'd8;
	localparam logic [3:0] S_CD     = 4'd9;
	localparam logic [3:0] S_WAIT   = 4'd10;
	localparam logic [3:0] S_FIN    = 4'd11;

	logic [3:0] state_q, ret_q;
	logic       axis_q, out_valid_q, load;

	assign in_ready  = state_q == S_IDLE;
	assign out_valid = out_valid_q;
	assign load      = (state_q == S_FIN) && (!out_valid_q || out_ready);

	always_comb begin
		cmd.in_take = in_valid && in_ready;
		cmd.axis    = axis_q;
		unique case (state_q)
			S_PRE:    cmd.op = OP_PRE;
			S_DA:     cmd.op = OP_DRAG_A;
			S_DB:     cmd.op = OP_DRAG_B;
			S_DC:     cmd.op = OP_DRAG_C;
			S_LAUNCH: cmd.op = OP_LAUNCH;
			S_CA:     cmd.op = OP_COAST_A;
			S_CB:     cmd.op = OP_COAST_B;
			S_CC:     cmd.op = OP_COAST_C;
			S_CD:     cmd.op = OP_COAST_D;
			S_FIN:    cmd.op = load ? OP_LOAD : OP_NONE;
			default:  cmd.op = OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ret_q       <= S_IDLE;
			axis_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_valid)
						state_q <= S_PRE;
				end
				S_PRE: begin
					axis_q  <= 1'b0;
					state_q <= stat.drag ? S_DA : S_LAUNCH;
				end
				S_DA: begin
					ret_q   <= S_DB;
					state_q <= S_WAIT;
				end
				S_DB: begin
					ret_q   <= S_DC;
					state_q <= S_WAIT;
				end
				S_DC: begin
					axis_q  <= 1'b1;
					state_q <= axis_q ? S_FIN : S_DA;
				end
				S_LAUNCH: state_q <= S_CA;
				S_CA:     state_q <= S_CB;
				S_CB:     state_q <= S_CC;
				S_CC: begin
					ret_q   <= S_CD;
					state_q <= S_WAIT;
				end
				S_CD: begin
					axis_q  <= 1'b1;
					state_q <= axis_q ? S_FIN : S_CA;
				end
				S_WAIT: begin
					if (stat.div_done)
						state_q <= ret_q;
				end
				S_FIN: begin
					if (load)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ----- sv/ise_checker.sv -----
module ise_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input logic signed [7:0] move_x_out,
	input logic signed [7:0] wheel_v_out,
	input logic              pready
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(move_x_out) && $stable(wheel_v_out))
		else $error("result changed while stalled");

	// one report at a time: busy right after a transaction
	a_in_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second report taken while busy");

	// a result never appears in the cycle right after a report is taken
	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !out_valid |=> !out_valid)
		else $error("result too early");

	a_pready: assert property (@(posedge clk) pready)
		else $error("pready low");

endmodule

bind inertial_scroll_engine ise_checker u_ise_checker (.*);

// ----- sim/inertial_scroll_engine_tb.sv -----
`timescale 1ns / 100ps

module inertial_scroll_engine_tb;
	import ise_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int RANDOM_REPORTS = 1050;

	typedef struct packed {
		logic [31:0]       time_ms;
		logic signed [7:0] move_x;
		logic signed [7:0] move_y;
		logic signed [7:0] wheel_h;
		logic signed [7:0] wheel_v;
		logic              buttons;
		logic              fn;
		logic              kill;
	} report_t;

	typedef struct packed {
		logic signed [7:0] move_x;
		logic signed [7:0] move_y;
		logic signed [7:0] wheel_h;
		logic signed [7:0] wheel_v;
	} scroll_out_t;

	// per-axis engine state, kept as wide signed integers
	typedef struct {
		longint remainder;
		longint avg;
		longint peak;
		longint peak_t;
		longint coast;
		longint frac;
		longint move_t;
	} axis_t;

	logic clk;
	logic arst_n;
	logic in_valid, in_ready;
	logic [31:0] time_ms;
	logic signed [7:0] move_x, move_y, wheel_h_in, wheel_v_in;
	logic buttons_active, fn_held, key_kill;
	logic out_valid, out_ready;
	logic signed [7:0] move_x_out, move_y_out, wheel_h_out, wheel_v_out;
	logic psel, penable, pwrite;
	logic [4:0] paddr;
	logic [31:0] pwdata, prdata;
	logic pready;

	inertial_scroll_engine uut (.*);

	report_t     pending_reports[$];
	scroll_out_t expected_results[$];
	int          fail_count;
	bit          idle_enable;
	int          quiet_cycles;
	logic        in_ready_q;

	// predictor copy of state and registers
	axis_t  axes[2];
	longint last_tick, last_touch;
	bit     drag_armed;
	cfg_t   cfg;
	logic [31:0] clock_ms;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic longint sat_127(longint v);
		return v > 127 ? 127 : (v < -127 ? -127 : v);
	endfunction

	function automatic longint absval(longint v);
		return v < 0 ? -v : v;
	endfunction

	function automatic longint drag_notches(int i, longint raw, longint now);
		longint dv, n, gap, inst;
		dv = (cfg.scroll_divisor == 0) ? 1 : cfg.scroll_divisor;
		axes[i].remainder += raw;
		n = axes[i].remainder / dv;
		axes[i].remainder -= n * dv;
		if (raw != 0) begin
			gap = (now - axes[i].move_t) & 64'hFFFF_FFFF;
			if (gap > 200) begin
				gap = 200;
				axes[i].avg = 0;
				axes[i].peak = 0;
			end else if (gap < 1)
				gap = 1;
			inst = raw * 1000000 / (dv * gap);
			if (inst > 8388607) inst = 8388607;
			if (inst < -8388607) inst = -8388607;
			axes[i].avg += (inst - axes[i].avg) / 4;
			if (absval(axes[i].avg) >= absval(axes[i].peak) ||
					((now - axes[i].peak_t) & 64'hFFFF_FFFF) > cfg.peak_hold_ms) begin
				axes[i].peak = axes[i].avg;
				axes[i].peak_t = now;
			end
			axes[i].move_t = now;
		end
		return n;
	endfunction

	function automatic void launch_coast(int i);
		longint v, mx, mn;
		v = axes[i].peak;
		mx = cfg.max_launch_speed;
		mn = cfg.min_launch_speed;
		if (v > mx) v = mx;
		if (v < -mx) v = -mx;
		if (v < mn && v > -mn) return;
		axes[i].coast = v;
		axes[i].frac = 0;
		axes[i].remainder = 0;
	endfunction

	function automatic longint coast_notches(int i, longint dt);
		longint n, decay, tau, st;
		tau = (cfg.decay_time_ms == 0) ? 1 : cfg.decay_time_ms;
		st = cfg.stop_speed;
		if (axes[i].coast == 0) return 0;
		axes[i].frac += axes[i].coast * dt / 1000;
		n = axes[i].frac / 1000;
		axes[i].frac -= n * 1000;
		decay = axes[i].coast * dt / tau;
		if (decay == 0) decay = axes[i].coast > 0 ? 1 : -1;
		if (absval(decay) > absval(axes[i].coast)) decay = axes[i].coast;
		axes[i].coast -= decay;
		if (axes[i].coast < st && axes[i].coast > -st) begin
			axes[i].coast = 0;
			axes[i].frac = 0;
		end
		return n;
	endfunction

	function automatic scroll_out_t predict_scroll(report_t r);
		scroll_out_t res;
		longint now, dt, dh, dv, x, y;
		bit moved;
		now = r.time_ms;
		x = r.move_x;
		y = r.move_y;
		moved = (x != 0 || y != 0);
		dt = (now - last_tick) & 64'hFFFF_FFFF;
		last_tick = now;
		if (dt < 1) dt = 1;
		if (dt > 100) dt = 100;
		dh = 0;
		dv = 0;
		if (moved || r.wheel_h != 0 || r.wheel_v != 0 || r.buttons || r.kill) begin
			for (int i = 0; i < 2; i++) begin
				axes[i].coast = 0;
				axes[i].frac = 0;
			end
			if (!r.fn || r.kill) drag_armed = 0;
		end
		if (r.fn && moved) begin
			dh = drag_notches(0, x, now);
			dv = drag_notches(1, cfg.y_negate ? -y : y, now);
			last_touch = now;
			drag_armed = 1;
		end else begin
			if (drag_armed && !moved &&
					((now - last_touch) & 64'hFFFF_FFFF) >= cfg.lift_timeout_ms) begin
				drag_armed = 0;
				launch_coast(0);
				launch_coast(1);
			end
			dh = coast_notches(0, dt);
			dv = coast_notches(1, dt);
		end
		res.move_x = r.fn ? 8'sd0 : 8'(sat_127(x));
		res.move_y = r.fn ? 8'sd0 : 8'(sat_127(y));
		res.wheel_h = 8'(sat_127(longint'(r.wheel_h) + dh));
		res.wheel_v = 8'(sat_127(longint'(r.wheel_v) + dv));
		return res;
	endfunction

	// driver: present the next report, hold it until accepted
	always @(negedge clk) begin
		if (arst_n && !(in_valid && !in_ready_q)) begin
			if (pending_reports.size() > 0 &&
					!(idle_enable && $urandom_range(99) < 24)) begin
				report_t r;
				r = pending_reports.pop_front();
				{time_ms, move_x, move_y, wheel_h_in, wheel_v_in,
					buttons_active, fn_held, key_kill} <= r;
				in_valid <= 1'b1;
			end else
				in_valid <= 1'b0;
		end
		out_ready <= !(idle_enable && $urandom_range(99) < 24);
	end

	// in_ready sampled at the edge: did the item on the port go in?
	always @(posedge clk) in_ready_q <= in_valid && in_ready ? 1'b1 : 1'b0;

	// monitor: predict on accepted reports, check accepted results
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (in_valid && in_ready) begin
				expected_results.push_back(predict_scroll({time_ms, move_x, move_y,
					wheel_h_in, wheel_v_in, buttons_active, fn_held, key_kill}));
			end
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					$error("result with no report outstanding");
					fail_count++;
				end else begin
					scroll_out_t e;
					e = expected_results.pop_front();
					if (move_x_out !== e.move_x) begin
						$error("move_x_out exp %0d got %0d", e.move_x, move_x_out);
						fail_count++;
					end
					if (move_y_out !== e.move_y) begin
						$error("move_y_out exp %0d got %0d", e.move_y, move_y_out);
						fail_count++;
					end
					if (wheel_h_out !== e.wheel_h) begin
						$error("wheel_h_out exp %0d got %0d", e.wheel_h, wheel_h_out);
						fail_count++;
					end
					if (wheel_v_out !== e.wheel_v) begin
						$error("wheel_v_out exp %0d got %0d", e.wheel_v, wheel_v_out);
						fail_count++;
					end
				end
			end
			if (quiet_cycles > WATCHDOG_LIMIT) begin
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	task automatic write_reg(logic [2:0] idx, logic [31:0] val);
		@(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_SCROLL_DIVISOR:   cfg.scroll_divisor = val[7:0];
			REG_Y_NEGATE:         cfg.y_negate = val[0];
			REG_MIN_LAUNCH_SPEED: cfg.min_launch_speed = val[16:0];
			REG_MAX_LAUNCH_SPEED: cfg.max_launch_speed = val[16:0];
			REG_DECAY_TIME_MS:    cfg.decay_time_ms = val[13:0];
			REG_STOP_SPEED:       cfg.stop_speed = val[16:0];
			REG_PEAK_HOLD_MS:     cfg.peak_hold_ms = val[9:0];
			REG_LIFT_TIMEOUT_MS:  cfg.lift_timeout_ms = val[9:0];
			default: ;
		endcase
	endtask

	// wait until the block has drained, then a margin for the last report
	task automatic drain();
		while (pending_reports.size() > 0 || in_valid || expected_results.size() > 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	function automatic report_t make_report(int gap, logic signed [7:0] mx,
			logic signed [7:0] my, logic signed [7:0] wh, logic signed [7:0] wv,
			bit b, bit f, bit k);
		report_t r;
		clock_ms += gap;
		r = '{clock_ms, mx, my, wh, wv, b, f, k};
		return r;
	endfunction

	function automatic logic signed [7:0] rand_delta();
		return $urandom_range(9) == 0 ? 8'($urandom) : 8'($urandom_range(40) - 20);
	endfunction

	// a drag gesture: fn held with motion, then quiet reports so a coast can run
	task automatic queue_gesture();
		int strokes;
		logic signed [7:0] sx, sy;
		strokes = $urandom_range(12, 3);
		sx = 8'($urandom_range(80) - 40);
		sy = 8'($urandom_range(80) - 40);
		for (int s = 0; s < strokes; s++)
			pending_reports.push_back(make_report($urandom_range(12, 1),
				sx + 8'($urandom_range(8) - 4), sy + 8'($urandom_range(8) - 4),
				0, 0, 0, 1, 0));
		for (int s = $urandom_range(25, 3); s > 0; s--)
			pending_reports.push_back(make_report($urandom_range(30, 1),
				0, 0, 0, 0, 0, $urandom_range(1), 0));
	endtask

	task automatic queue_noise();
		pending_reports.push_back(make_report(
			$urandom_range(4) == 0 ? $urandom : $urandom_range(150),
			rand_delta(), rand_delta(), rand_delta(), rand_delta(),
			$urandom_range(7) == 0, $urandom_range(1), $urandom_range(7) == 0));
	endtask

	task automatic random_phase(int count);
		int queued;
		queued = 0;
		while (queued < count) begin
			if ($urandom_range(99) < 70) begin
				queue_gesture();
				queued += 20;
			end else begin
				queue_noise();
				queued++;
			end
			while (pending_reports.size() > 8) @(posedge clk);
		end
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		out_ready = 1'b0;
		{time_ms, move_x, move_y, wheel_h_in, wheel_v_in} = '0;
		{buttons_active, fn_held, key_kill} = '0;
		{psel, penable, pwrite, paddr, pwdata} = '0;
		fail_count = 0;
		quiet_cycles = 0;
		idle_enable = 1'b1;
		clock_ms = 0;
		foreach (axes[i]) axes[i] = '{0, 0, 0, 0, 0, 0, 0};
		last_tick = 0;
		last_touch = 0;
		drag_armed = 0;
		cfg = '{RST_SCROLL_DIVISOR, RST_Y_NEGATE, RST_MIN_LAUNCH_SPEED,
			RST_MAX_LAUNCH_SPEED, RST_DECAY_TIME_MS, RST_STOP_SPEED,
			RST_PEAK_HOLD_MS, RST_LIFT_TIMEOUT_MS};
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: extremes, zero tick, wrapped time, kill, buttons, coast
		pending_reports.push_back(make_report(0, 8'sh80, 8'sh80, 8'sh80, 8'sh80, 0, 0, 0));
		pending_reports.push_back(make_report(0, 127, 127, 127, 127, 1, 0, 1));
		pending_reports.push_back(make_report(5, 127, -128, 0, 0, 0, 1, 0));
		pending_reports.push_back(make_report(1, 127, -128, 0, 0, 0, 1, 0));
		pending_reports.push_back(make_report(300, 127, 127, 0, 0, 0, 1, 0));
		pending_reports.push_back(make_report(2, 90, -90, 0, 0, 0, 1, 0));
		pending_reports.push_back(make_report(40, 0, 0, 0, 0, 0, 1, 0));
		for (int i = 0; i < 6; i++)
			pending_reports.push_back(make_report(100, 0, 0, 0, 0, 0, 0, 0));
		pending_reports.push_back(make_report(3, 0, 0, 0, 0, 0, 0, 1));
		clock_ms = 32'hFFFF_FFF0;
		pending_reports.push_back(make_report(0, 30, 30, 127, -127, 0, 1, 0));
		pending_reports.push_back(make_report(32, 40, 40, 0, 0, 0, 1, 0));
		pending_reports.push_back(make_report(30, 0, 0, 0, 0, 0, 0, 0));
		pending_reports.push_back(make_report(500, 0, 0, 0, 0, 0, 0, 0));
		drain();

		// register settings in turn, including zero divisor and zero decay time
		idle_enable = 1'b0;
		write_reg(REG_SCROLL_DIVISOR, 0);
		write_reg(REG_Y_NEGATE, 1);
		write_reg(REG_MIN_LAUNCH_SPEED, 0);
		write_reg(REG_MAX_LAUNCH_SPEED, 100000);
		write_reg(REG_DECAY_TIME_MS, 0);
		write_reg(REG_STOP_SPEED, 0);
		write_reg(REG_PEAK_HOLD_MS, 0);
		write_reg(REG_LIFT_TIMEOUT_MS, 0);
		random_phase(150);
		idle_enable = 1'b1;

		write_reg(REG_SCROLL_DIVISOR, 255);
		write_reg(REG_Y_NEGATE, 0);
		write_reg(REG_MIN_LAUNCH_SPEED, 100000);
		write_reg(REG_MAX_LAUNCH_SPEED, 0);
		write_reg(REG_DECAY_TIME_MS, 10000);
		write_reg(REG_STOP_SPEED, 100000);
		write_reg(REG_PEAK_HOLD_MS, 1000);
		write_reg(REG_LIFT_TIMEOUT_MS, 1000);
		random_phase(150);

		write_reg(REG_SCROLL_DIVISOR, 1);
		write_reg(REG_MIN_LAUNCH_SPEED, 1000);
		write_reg(REG_MAX_LAUNCH_SPEED, 100000);
		write_reg(REG_DECAY_TIME_MS, 2000);
		write_reg(REG_STOP_SPEED, 500);
		write_reg(REG_PEAK_HOLD_MS, 50);
		write_reg(REG_LIFT_TIMEOUT_MS, 15);
		random_phase(150);

		// reset-like settings: the bulk of the random traffic
		write_reg(REG_SCROLL_DIVISOR, RST_SCROLL_DIVISOR);
		write_reg(REG_MIN_LAUNCH_SPEED, RST_MIN_LAUNCH_SPEED);
		write_reg(REG_MAX_LAUNCH_SPEED, RST_MAX_LAUNCH_SPEED);
		write_reg(REG_DECAY_TIME_MS, RST_DECAY_TIME_MS);
		write_reg(REG_STOP_SPEED, RST_STOP_SPEED);
		write_reg(REG_PEAK_HOLD_MS, RST_PEAK_HOLD_MS);
		write_reg(REG_LIFT_TIMEOUT_MS, RST_LIFT_TIMEOUT_MS);
		random_phase(RANDOM_REPORTS - 450);

		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
